/* rtl/cmvw_pkg.sv */
// Shared constants and helper functions for the variable-width MSB-first CRC block.
package cmvw_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned CRC_W       = 64;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_WIDTH_W = 7;
    localparam int unsigned MIN_WIDTH   = 8;
    localparam int unsigned MAX_WIDTH_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0] RST_CRC_WIDTH     = 7'd32;
    localparam logic [CFG_DATA_W-1:0]  RST_POLYNOMIAL    = 64'h0000_0000_04C1_1DB7;
    localparam logic [CFG_DATA_W-1:0]  RST_INITIAL_VALUE = 64'h0000_0000_FFFF_FFFF;

    // Saturate a width to the supported range.
    function automatic int unsigned cmvw_clamp(input int unsigned w, input int unsigned max_w);
        int unsigned r;
        r = w;
        if (r < MIN_WIDTH)
        begin
            r = MIN_WIDTH;
        end
        if (r > max_w)
        begin
            r = max_w;
        end
        return r;
    endfunction

    // Keep the low width bits and left-align them to the top of a max_w-bit register.
    function automatic logic [CRC_W-1:0] cmvw_align(input logic [CRC_W-1:0] v,
                                                    input int unsigned width,
                                                    input int unsigned max_w);
        logic [CRC_W-1:0] m;
        m = v << (CRC_W - width);
        m = m >> (CRC_W - max_w);
        return m;
    endfunction

endpackage

/* rtl/cmvw_if.sv */
// Valid/ready channel interfaces for message bytes and finished CRC words.
interface cmvw_byte_if;
    logic                        valid;
    logic                        ready;
    logic [cmvw_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cmvw_crc_if;
    logic                       valid;
    logic                       ready;
    logic [cmvw_pkg::CRC_W-1:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

/* rtl/cmvw_cfg.sv */
// Configuration registers and width-aligned polynomial and initial value.
module cmvw_cfg #(
    parameter int unsigned MAX_WIDTH = cmvw_pkg::MAX_WIDTH_DEF,
    localparam int unsigned SHAMT_W  = (MAX_WIDTH > 8) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_en,
    input  logic [cmvw_pkg::CFG_IDX_W-1:0]      reg_index,
    input  logic [cmvw_pkg::CFG_DATA_W-1:0]     write_data,
    output logic [SHAMT_W-1:0]                  shamt,
    output logic [MAX_WIDTH-1:0]                poly_al,
    output logic [MAX_WIDTH-1:0]                init_al,
    output logic                                reload,
    output logic [MAX_WIDTH-1:0]                init_al_next
);

    localparam int unsigned RST_W = cmvw_pkg::cmvw_clamp(32, MAX_WIDTH);
    localparam logic [cmvw_pkg::CRC_W-1:0] RST_POLY_AL =
        cmvw_pkg::cmvw_align(cmvw_pkg::RST_POLYNOMIAL, RST_W, MAX_WIDTH);
    localparam logic [cmvw_pkg::CRC_W-1:0] RST_INIT_AL =
        cmvw_pkg::cmvw_align(cmvw_pkg::RST_INITIAL_VALUE, RST_W, MAX_WIDTH);
    localparam logic [SHAMT_W-1:0] RST_SHAMT = SHAMT_W'(MAX_WIDTH - RST_W);
    localparam logic [cmvw_pkg::CFG_WIDTH_W-1:0] MAX_W7 = cmvw_pkg::CFG_WIDTH_W'(MAX_WIDTH);
    localparam logic [cmvw_pkg::CFG_WIDTH_W-1:0] MIN_W7 =
        cmvw_pkg::CFG_WIDTH_W'(cmvw_pkg::MIN_WIDTH);

    logic [cmvw_pkg::CFG_WIDTH_W-1:0] width_reg, width_next;
    logic [cmvw_pkg::CFG_DATA_W-1:0]  poly_reg, poly_next;
    logic [cmvw_pkg::CFG_DATA_W-1:0]  init_reg, init_next;
    logic [SHAMT_W-1:0]               shamt_reg, shamt_next;
    logic [MAX_WIDTH-1:0]             poly_al_reg, poly_al_next;
    logic [MAX_WIDTH-1:0]             init_al_reg;
    logic [cmvw_pkg::CFG_WIDTH_W-1:0] eff_w;
    logic [cmvw_pkg::CFG_WIDTH_W-1:0] shamt_w7;
    logic                             hit;

    always_comb
    begin
        width_next = width_reg;
        poly_next  = poly_reg;
        init_next  = init_reg;
        hit        = 1'b0;
        if (write_en)
        begin
            unique case (reg_index)
                cmvw_pkg::REG_CRC_WIDTH:
                begin
                    width_next = write_data[cmvw_pkg::CFG_WIDTH_W-1:0];
                    hit        = 1'b1;
                end
                cmvw_pkg::REG_POLYNOMIAL:
                begin
                    poly_next = write_data;
                    hit       = 1'b1;
                end
                cmvw_pkg::REG_INITIAL_VALUE:
                begin
                    init_next = write_data;
                    hit       = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end

        eff_w = width_next;
        if (eff_w < MIN_W7)
        begin
            eff_w = MIN_W7;
        end
        if (eff_w > MAX_W7)
        begin
            eff_w = MAX_W7;
        end
        shamt_w7     = MAX_W7 - eff_w;
        shamt_next   = shamt_w7[SHAMT_W-1:0];
        poly_al_next = poly_next[MAX_WIDTH-1:0] << shamt_next;
        init_al_next = init_next[MAX_WIDTH-1:0] << shamt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= cmvw_pkg::RST_CRC_WIDTH;
            poly_reg    <= cmvw_pkg::RST_POLYNOMIAL;
            init_reg    <= cmvw_pkg::RST_INITIAL_VALUE;
            shamt_reg   <= RST_SHAMT;
            poly_al_reg <= RST_POLY_AL[MAX_WIDTH-1:0];
            init_al_reg <= RST_INIT_AL[MAX_WIDTH-1:0];
        end
        else if (hit)
        begin
            width_reg   <= width_next;
            poly_reg    <= poly_next;
            init_reg    <= init_next;
            shamt_reg   <= shamt_next;
            poly_al_reg <= poly_al_next;
            init_al_reg <= init_al_next;
        end
    end

    assign shamt   = shamt_reg;
    assign poly_al = poly_al_reg;
    assign init_al = init_al_reg;
    assign reload  = hit;

endmodule

/* rtl/cmvw_core.sv */
// Input register, eight-step byte update of the left-aligned CRC, and result register.
module cmvw_core #(
    parameter int unsigned MAX_WIDTH = cmvw_pkg::MAX_WIDTH_DEF,
    localparam int unsigned SHAMT_W  = (MAX_WIDTH > 8) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cmvw_byte_if.sink            msg,
    cmvw_crc_if.source           crc,
    input  logic [SHAMT_W-1:0]   shamt,
    input  logic [MAX_WIDTH-1:0] poly_al,
    input  logic [MAX_WIDTH-1:0] init_al,
    input  logic                 reload,
    input  logic [MAX_WIDTH-1:0] init_al_next
);

    localparam int unsigned RST_W = cmvw_pkg::cmvw_clamp(32, MAX_WIDTH);
    localparam logic [cmvw_pkg::CRC_W-1:0] RST_INIT_AL =
        cmvw_pkg::cmvw_align(cmvw_pkg::RST_INITIAL_VALUE, RST_W, MAX_WIDTH);

    logic                          in_vld_reg;
    logic [cmvw_pkg::DATA_W-1:0]   byte_reg;
    logic                          last_reg;
    logic [MAX_WIDTH-1:0]          crc_reg;
    logic                          out_vld_reg;
    logic [cmvw_pkg::CRC_W-1:0]    crc_value_reg;
    logic [MAX_WIDTH-1:0]          crc_next;
    logic [MAX_WIDTH-1:0]          crc_out;
    logic                          adv;
    logic                          fb;

    assign adv       = !out_vld_reg || crc.ready;
    assign msg.ready = !in_vld_reg || adv;

    always_comb
    begin
        crc_next = crc_reg;
        crc_next[MAX_WIDTH-1 -: cmvw_pkg::DATA_W] =
            crc_reg[MAX_WIDTH-1 -: cmvw_pkg::DATA_W] ^ byte_reg;
        for (int k = 0; k < cmvw_pkg::DATA_W; k++)
        begin
            fb       = crc_next[MAX_WIDTH-1];
            crc_next = {crc_next[MAX_WIDTH-2:0], 1'b0} ^ (fb ? poly_al : '0);
        end
        crc_out = crc_next >> shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (msg.valid && msg.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            byte_reg <= msg.data_byte;
            last_reg <= msg.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= RST_INIT_AL[MAX_WIDTH-1:0];
        end
        else if (reload)
        begin
            crc_reg <= init_al_next;
        end
        else if (adv && in_vld_reg)
        begin
            crc_reg <= last_reg ? init_al : crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= in_vld_reg && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_vld_reg && last_reg)
        begin
            crc_value_reg <= cmvw_pkg::CRC_W'(crc_out);
        end
    end

    assign crc.valid     = out_vld_reg;
    assign crc.crc_value = crc_value_reg;

endmodule

/* rtl/crc_msb_first_variable_width.sv */
// Top level of the configurable-width MSB-first CRC engine over a byte stream.
//
//  channel  dir  payload                  word
//  msg      in   data_byte[7:0], last_byte  one message byte
//  crc      out  crc_value[63:0]            finished CRC, on last byte only
//  config   in   write_en, reg_index, write_data  register write, no read-back
//
//  One byte per cycle unless the result stalls; the eight shift/XOR steps are
//  combinational between the input register and the CRC register. The CRC word
//  is registered as its last byte leaves the input register. Reset loads width
//  32, CRC-32 polynomial and all-ones start value. A stalled result holds in
//  the output register while one more byte waits in the input register.
module crc_msb_first_variable_width #(
    parameter int unsigned MAX_WIDTH = cmvw_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cmvw_byte_if.sink                       msg,
    cmvw_crc_if.source                      crc,
    input  logic                            write_en,
    input  logic [cmvw_pkg::CFG_IDX_W-1:0]  reg_index,
    input  logic [cmvw_pkg::CFG_DATA_W-1:0] write_data
);

    localparam int unsigned SHAMT_W = (MAX_WIDTH > 8) ? $clog2(MAX_WIDTH) : 1;

    logic [SHAMT_W-1:0]   shamt;
    logic [MAX_WIDTH-1:0] poly_al;
    logic [MAX_WIDTH-1:0] init_al;
    logic                 reload;
    logic [MAX_WIDTH-1:0] init_al_next;

    cmvw_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_en     (write_en),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .shamt        (shamt),
        .poly_al      (poly_al),
        .init_al      (init_al),
        .reload       (reload),
        .init_al_next (init_al_next)
    );

    cmvw_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg          (msg),
        .crc          (crc),
        .shamt        (shamt),
        .poly_al      (poly_al),
        .init_al      (init_al),
        .reload       (reload),
        .init_al_next (init_al_next)
    );

endmodule

/* tb/crc_msb_first_variable_width_test.sv */
// Self-checking testbench for the variable-width MSB-first CRC engine.
module crc_msb_first_variable_width_test;

    localparam logic [cmvw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 1600;
    localparam int PLAN_ROWS     = 38;

    typedef enum logic [0:0] {ROW_BYTE, ROW_WRITE} row_kind_t;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_LONG} sink_mode_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [cmvw_pkg::CFG_IDX_W-1:0]   idx;
        logic [cmvw_pkg::CFG_DATA_W-1:0]  value;
        logic                             last;
        logic                             pinned;
        logic [cmvw_pkg::CRC_W-1:0]       crc;
    } row_t;

    function automatic row_t row_byte(input logic [7:0] b, input logic l);
        return '{ROW_BYTE, cmvw_pkg::REG_CRC_WIDTH, {56'd0, b}, l, 1'b0, '0};
    endfunction

    function automatic row_t row_check(input logic [7:0] b,
                                       input logic [cmvw_pkg::CRC_W-1:0] c);
        return '{ROW_BYTE, cmvw_pkg::REG_CRC_WIDTH, {56'd0, b}, 1'b1, 1'b1, c};
    endfunction

    function automatic row_t row_write(input logic [cmvw_pkg::CFG_IDX_W-1:0] i,
                                       input logic [cmvw_pkg::CFG_DATA_W-1:0] v);
        return '{ROW_WRITE, i, v, 1'b0, 1'b0, '0};
    endfunction

    localparam row_t PLAN [PLAN_ROWS] = '{
        row_byte(8'h31, 1'b0), row_byte(8'h32, 1'b0), row_byte(8'h33, 1'b0),
        row_byte(8'h34, 1'b0), row_byte(8'h35, 1'b0), row_byte(8'h36, 1'b0),
        row_byte(8'h37, 1'b0), row_byte(8'h38, 1'b0),
        row_check(8'h39, 64'h0000_0000_0376_E6E7),
        row_write(cmvw_pkg::REG_CRC_WIDTH, 64'hFFFF_FFFF_FFFF_FF80),
        row_write(cmvw_pkg::REG_POLYNOMIAL, 64'hFFFF_FFFF_FFFF_FF07),
        row_write(cmvw_pkg::REG_INITIAL_VALUE, 64'hFFFF_FFFF_FFFF_FF00),
        row_check(8'h00, 64'h0),
        row_byte(8'h31, 1'b0), row_byte(8'h32, 1'b0), row_byte(8'h33, 1'b0),
        row_byte(8'h34, 1'b0), row_byte(8'h35, 1'b0), row_byte(8'h36, 1'b0),
        row_byte(8'h37, 1'b0), row_byte(8'h38, 1'b0),
        row_check(8'h39, 64'h0000_0000_0000_00F4),
        row_byte(8'hA5, 1'b0),
        row_write(REG_UNUSED, 64'h5A5A_C3C3_0F0F_9696),
        row_byte(8'h3C, 1'b1),
        row_write(cmvw_pkg::REG_CRC_WIDTH, 64'h0000_0000_0000_007F),
        row_write(cmvw_pkg::REG_POLYNOMIAL, 64'hFFFF_FFFF_FFFF_FFFF),
        row_write(cmvw_pkg::REG_INITIAL_VALUE, 64'hFFFF_FFFF_FFFF_FFFF),
        row_byte(8'hFF, 1'b1),
        row_write(cmvw_pkg::REG_CRC_WIDTH, 64'h0000_0000_0000_0007),
        row_byte(8'h80, 1'b1),
        row_write(cmvw_pkg::REG_CRC_WIDTH, 64'h0000_0000_0000_0009),
        row_byte(8'hFF, 1'b0),
        row_write(cmvw_pkg::REG_INITIAL_VALUE, 64'h0),
        row_check(8'h00, 64'h0),
        row_write(cmvw_pkg::REG_CRC_WIDTH, 64'h0000_0000_0000_0040),
        row_write(cmvw_pkg::REG_POLYNOMIAL, 64'h42F0_E1EB_A9EA_3693),
        row_byte(8'h80, 1'b1)
    };

    logic clk = 1'b0;
    logic rst_n;
    logic write_en;
    logic [cmvw_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [cmvw_pkg::CFG_DATA_W-1:0] write_data;

    cmvw_byte_if msg_ch ();
    cmvw_crc_if  crc_ch ();

    crc_msb_first_variable_width u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg_ch),
        .crc        (crc_ch),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data)
    );

    logic [cmvw_pkg::CFG_WIDTH_W-1:0] cfg_width = cmvw_pkg::RST_CRC_WIDTH;
    logic [cmvw_pkg::CFG_DATA_W-1:0]  cfg_poly  = cmvw_pkg::RST_POLYNOMIAL;
    logic [cmvw_pkg::CFG_DATA_W-1:0]  cfg_init  = cmvw_pkg::RST_INITIAL_VALUE;
    logic [cmvw_pkg::CRC_W-1:0]       crc_reg   = cmvw_pkg::RST_INITIAL_VALUE;
    logic [cmvw_pkg::CRC_W-1:0]       pending_crc [$];
    logic                             pin_on = 1'b0;
    logic [cmvw_pkg::CRC_W-1:0]       pin_crc = '0;
    int                               mismatch_count = 0;
    int                               cycle_count = 0;
    int                               burst_left = 0;
    int                               gap_max = 3;
    sink_mode_t                       sink_mode = SINK_OPEN;
    logic [15:0]                      stall_pat = 16'hFFFF;
    logic [3:0]                       pat_pos = '0;
    int                               hold_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < cmvw_pkg::MIN_WIDTH)
        begin
            w = cmvw_pkg::MIN_WIDTH;
        end
        if (w > cmvw_pkg::MAX_WIDTH_DEF)
        begin
            w = cmvw_pkg::MAX_WIDTH_DEF;
        end
        return w;
    endfunction

    function automatic logic [cmvw_pkg::CRC_W-1:0] width_mask(input int w);
        if (w >= cmvw_pkg::CRC_W)
        begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [cmvw_pkg::CRC_W-1:0] fold_byte(
        input logic [cmvw_pkg::CRC_W-1:0] r,
        input logic [7:0] b);
        int w;
        int k;
        logic [cmvw_pkg::CRC_W-1:0] m;
        logic [cmvw_pkg::CRC_W-1:0] p;
        logic fb;
        w = eff_width();
        m = width_mask(w);
        p = cfg_poly & m;
        r = r & m;
        r = r ^ (({56'd0, b} << (w - 8)) & m);
        for (k = 0; k < 8; k++)
        begin
            fb = r[w-1];
            r = (r << 1) & m;
            if (fb)
            begin
                r = r ^ p;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        case (sink_mode)
            SINK_OPEN:
            begin
                crc_ch.ready <= 1'b1;
            end
            SINK_COIN:
            begin
                crc_ch.ready <= ($urandom_range(0, 2) != 0);
            end
            SINK_PATTERN:
            begin
                crc_ch.ready <= stall_pat[pat_pos];
                pat_pos <= pat_pos + 4'd1;
            end
            default:
            begin
                if (hold_left != 0)
                begin
                    crc_ch.ready <= 1'b0;
                    hold_left <= hold_left - 1;
                end
                else
                begin
                    crc_ch.ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        hold_left <= $urandom_range(4, 24);
                    end
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        logic [cmvw_pkg::CRC_W-1:0] folded;
        logic [cmvw_pkg::CRC_W-1:0] want;
        if (rst_n)
        begin
            if (write_en && reg_index != REG_UNUSED)
            begin
                case (reg_index)
                    cmvw_pkg::REG_CRC_WIDTH:
                        cfg_width = write_data[cmvw_pkg::CFG_WIDTH_W-1:0];
                    cmvw_pkg::REG_POLYNOMIAL:
                        cfg_poly = write_data;
                    default:
                        cfg_init = write_data;
                endcase
                crc_reg = cfg_init & width_mask(eff_width());
            end
            if (msg_ch.valid && msg_ch.ready)
            begin
                folded = fold_byte(crc_reg, msg_ch.data_byte);
                if (msg_ch.last_byte)
                begin
                    pending_crc.push_back(pin_on ? pin_crc : folded);
                    crc_reg = cfg_init & width_mask(eff_width());
                end
                else
                begin
                    crc_reg = folded;
                end
            end
            if (crc_ch.valid && crc_ch.ready)
            begin
                if (pending_crc.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected crc word %h", crc_ch.crc_value);
                    end
                end
                else
                begin
                    want = pending_crc.pop_front();
                    if (crc_ch.crc_value !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("crc word mismatch: expected %h, got %h",
                                     want, crc_ch.crc_value);
                        end
                    end
                end
            end
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic l,
                             input logic pin, input logic [cmvw_pkg::CRC_W-1:0] pcrc);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        pin_on = pin;
        pin_crc = pcrc;
        msg_ch.valid <= 1'b1;
        msg_ch.data_byte <= b;
        msg_ch.last_byte <= l;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic settle();
        msg_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_crc.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // leaves write_en high; the caller drops it
    task automatic write_reg(input logic [cmvw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmvw_pkg::CFG_DATA_W-1:0] value);
        write_en <= 1'b1;
        reg_index <= idx;
        write_data <= value;
        @(negedge clk);
    endtask

    function automatic logic [cmvw_pkg::CFG_DATA_W-1:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int i;
        int bytes_left;
        int phase_bytes;
        int len;
        int k;
        logic writing;
        logic [cmvw_pkg::CFG_DATA_W-1:0] value;

        rst_n = 1'b0;
        write_en = 1'b0;
        reg_index = cmvw_pkg::REG_CRC_WIDTH;
        write_data = '0;
        msg_ch.valid = 1'b0;
        msg_ch.data_byte = '0;
        msg_ch.last_byte = 1'b0;
        crc_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        writing = 1'b0;
        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    settle();
                end
                write_reg(PLAN[i].idx, PLAN[i].value);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                begin
                    write_en <= 1'b0;
                    writing = 1'b0;
                end
                send_byte(PLAN[i].value[7:0], PLAN[i].last, PLAN[i].pinned, PLAN[i].crc);
            end
        end

        bytes_left = RANDOM_BYTES;
        while (bytes_left > 0)
        begin
            settle();
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            stall_pat = 16'($urandom) | 16'h0001;

            if ($urandom_range(0, 3) != 0)
            begin
                value = {$urandom, $urandom};
                case ($urandom_range(0, 5))
                    0:       value[6:0] = 7'($urandom_range(0, 8));
                    1:       value[6:0] = 7'($urandom_range(64, 127));
                    2:       value[6:0] = $urandom_range(0, 1) ? 7'd8 : 7'd64;
                    default: value[6:0] = 7'($urandom_range(8, 64));
                endcase
                write_reg(cmvw_pkg::REG_CRC_WIDTH, value);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(cmvw_pkg::REG_POLYNOMIAL, pick_word());
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(cmvw_pkg::REG_INITIAL_VALUE, pick_word());
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_UNUSED, {$urandom, $urandom});
            end
            write_en <= 1'b0;

            phase_bytes = $urandom_range(40, 160);
            if (phase_bytes > bytes_left)
            begin
                phase_bytes = bytes_left;
            end
            bytes_left -= phase_bytes;
            while (phase_bytes > 0)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
                // a message cut short by the phase end is dropped by the next write
                for (k = 0; k < len && phase_bytes > 0; k++)
                begin
                    send_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0, '0);
                    phase_bytes--;
                end
            end
        end
        settle();

        if (mismatch_count == 0 && pending_crc.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/cmvw_pkg.sv
rtl/cmvw_if.sv
rtl/cmvw_cfg.sv
rtl/cmvw_core.sv
rtl/crc_msb_first_variable_width.sv
tb/crc_msb_first_variable_width_test.sv
